// File: sv/thbf_pkg.sv
`timescale 1ns / 1ps

package thbf_pkg;

    // Filter size and derived widths
    localparam int MAX_BITS = 524288;
    localparam int CFG_W    = 20;
    localparam int NW       = $clog2(MAX_BITS + 1);
    localparam int ROW_W    = (MAX_BITS < 64) ? 8 : 64;
    localparam int BIT_AW   = $clog2(ROW_W);
    localparam int ROWS     = (MAX_BITS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Hash constants
    localparam int HASH_W = 64;
    localparam logic [HASH_W-1:0] DJB_SEED = 64'd5381;
    localparam logic [HASH_W-1:0] ELF_TOP  = 64'h0000_0000_F000_0000;
    localparam logic [CFG_W-1:0]  BIT_COUNT_RESET = CFG_W'(16377 * 32);

    // Modulo unit: remainder bits per cycle
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYC   = HASH_W / DIV_STEPS;
    localparam int DIV_CW    = $clog2(DIV_CYC);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CHECK = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_PRESENT  = 2'd2,
        ST_INACTIVE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_DIV,
        BK_READ,
        BK_USE,
        BK_CLEAR,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] items_added;
    } out_item_t;

    // One finished key, handed from front to back
    typedef struct packed {
        logic [1:0]        action;
        logic [HASH_W-1:0] elf;
        logic [HASH_W-1:0] djb;
        logic [HASH_W-1:0] bkdr;
    } job_t;

endpackage

// File: sv/three_hash_bloom_filter.sv
`timescale 1ns / 1ps
// Channel    Handshake                 Payload
// in         in_valid / in_stall       in_data   (action, key_byte, last_byte)
// out        out_valid / out_stall     out_data  (status, items_added)
// cfg        cfg_wr_en                 cfg_wr_data (bit_count)
//
// Key bytes are taken one per cycle while in_stall is low; the three hashes fold in the same cycle.
// Per key the back end dispatches the request, runs the modulo unit (4 remainder bits a cycle,
// 64-bit hashes), then for an add or a check of an active filter does a registered row read,
// then a set or test, for each of the three bits, then holds the result until it is taken.
// A clear sweeps the 8192-row store, one row a cycle, before its result.
// After reset the same sweep runs with in_stall high.
// A two-entry queue holds finished keys, so bytes keep flowing while a result waits.

module three_hash_bloom_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  thbf_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output thbf_pkg::out_item_t            out_data,
    input  logic                           cfg_wr_en,
    input  logic [thbf_pkg::CFG_W-1:0]     cfg_wr_data
);

    logic [thbf_pkg::CFG_W-1:0] bit_count_reg;
    logic                       q_push, q_pop, q_full, q_empty, init_busy;
    thbf_pkg::job_t             q_in, q_out;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= thbf_pkg::BIT_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            bit_count_reg <= cfg_wr_data;
        end
    end

    thbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .hold     (q_full | init_busy),
        .in_stall (in_stall),
        .push     (q_push),
        .job      (q_in)
    );

    thbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    thbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_count (bit_count_reg),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("key pushed into a full queue");

    a_stall_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> in_stall)
        else $error("input taken during the clearing sweep");

    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated after hand-over");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from an empty queue");
`endif

endmodule

// File: sv/thbf_ram.sv
`timescale 1ns / 1ps

module thbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/thbf_front.sv
`timescale 1ns / 1ps

module thbf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  thbf_pkg::in_item_t  in_data,
    input  logic                hold,
    output logic                in_stall,
    output logic                push,
    output thbf_pkg::job_t      job
);

    logic [thbf_pkg::HASH_W-1:0] elf_reg, elf_next;
    logic [thbf_pkg::HASH_W-1:0] djb_reg, djb_next;
    logic [thbf_pkg::HASH_W-1:0] bkdr_reg, bkdr_next;
    logic [thbf_pkg::HASH_W-1:0] c;
    logic [thbf_pkg::HASH_W-1:0] e1;
    logic [thbf_pkg::HASH_W-1:0] top;
    logic                        accept;

    assign in_stall = hold;
    assign accept   = in_valid & ~in_stall;

    // Fold one sign-extended byte into the three hashes
    always_comb
    begin
        c         = {{(thbf_pkg::HASH_W-8){in_data.key_byte[7]}}, in_data.key_byte};
        e1        = (elf_reg << 4) + c;
        top       = e1 & thbf_pkg::ELF_TOP;
        elf_next  = (e1 ^ (top >> 24)) & ~top;
        djb_next  = (djb_reg << 5) + djb_reg + c;
        bkdr_next = (bkdr_reg << 7) + (bkdr_reg << 1) + bkdr_reg + c;
    end

    // Hand a finished key to the queue
    assign push       = accept & in_data.last_byte;
    assign job.action = in_data.action;
    assign job.elf    = elf_next;
    assign job.djb    = djb_next;
    assign job.bkdr   = bkdr_next;

    // Advance hashes, reseed after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elf_reg  <= '0;
            djb_reg  <= thbf_pkg::DJB_SEED;
            bkdr_reg <= '0;
        end
        else if (accept)
        begin
            if (in_data.last_byte)
            begin
                elf_reg  <= '0;
                djb_reg  <= thbf_pkg::DJB_SEED;
                bkdr_reg <= '0;
            end
            else
            begin
                elf_reg  <= elf_next;
                djb_reg  <= djb_next;
                bkdr_reg <= bkdr_next;
            end
        end
    end

endmodule

// File: sv/thbf_queue.sv
`timescale 1ns / 1ps

module thbf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  thbf_pkg::job_t  push_data,
    input  logic            pop,
    output thbf_pkg::job_t  pop_data,
    output logic            full,
    output logic            empty
);

    thbf_pkg::job_t slot_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: sv/thbf_back.sv
`timescale 1ns / 1ps

module thbf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [thbf_pkg::CFG_W-1:0]     bit_count,
    input  logic                           q_empty,
    input  thbf_pkg::job_t                 q_data,
    output logic                           q_pop,
    output logic                           init_busy,
    output logic                           out_valid,
    input  logic                           out_stall,
    output thbf_pkg::out_item_t            out_data
);

    localparam int NW     = thbf_pkg::NW;
    localparam int ROW_AW = thbf_pkg::ROW_AW;
    localparam int ROW_W  = thbf_pkg::ROW_W;
    localparam int BIT_AW = thbf_pkg::BIT_AW;
    localparam int HW     = thbf_pkg::HASH_W;

    thbf_pkg::back_state_t state_reg, state_next;
    thbf_pkg::act_t        act_reg, act_next;
    logic [HW-1:0]         div_reg [3];
    logic [HW-1:0]         div_next [3];
    logic [NW-1:0]         rem_reg [3];
    logic [NW-1:0]         rem_next [3];
    logic [NW-1:0]         n_reg, n_next, n_used;
    logic [thbf_pkg::DIV_CW-1:0] step_reg, step_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic                  active_reg, active_next;
    logic [31:0]           count_reg, count_next;
    logic [1:0]            status_reg, status_next;
    logic [ROW_AW-1:0]     row_reg, row_next;

    logic                  ram_we;
    logic [ROW_AW-1:0]     ram_waddr, ram_raddr, pos_row;
    logic [ROW_W-1:0]      ram_wdata, ram_rdata;
    logic [BIT_AW-1:0]     pos_bit;

    // Several remainder bits of one lane per cycle
    function automatic logic [NW+HW-1:0] div_step(
        input logic [NW-1:0] r_in,
        input logic [HW-1:0] d_in,
        input logic [NW-1:0] n
    );
        logic [NW:0]   t;
        logic [NW-1:0] r;
        logic [HW-1:0] d;
        r = r_in;
        d = d_in;
        for (int k = 0; k < thbf_pkg::DIV_STEPS; k++)
        begin
            t = {r, d[HW-1]};
            d = d << 1;
            if (t >= {1'b0, n})
            begin
                t = t - {1'b0, n};
            end
            r = t[NW-1:0];
        end
        return {r, d};
    endfunction

    thbf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (thbf_pkg::ROWS)
    ) u_bits (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Bit count in use: zero becomes one, large values saturate
    always_comb
    begin
        if (bit_count == '0)
        begin
            n_used = NW'(1);
        end
        else if (32'(bit_count) > 32'(thbf_pkg::MAX_BITS))
        begin
            n_used = NW'(thbf_pkg::MAX_BITS);
        end
        else
        begin
            n_used = NW'(bit_count);
        end
    end

    assign pos_row   = ROW_AW'(rem_reg[idx_reg] >> BIT_AW);
    assign pos_bit   = rem_reg[idx_reg][BIT_AW-1:0];
    assign ram_raddr = pos_row;

    assign init_busy          = (state_reg == thbf_pkg::BK_INIT);
    assign out_valid          = (state_reg == thbf_pkg::BK_OUT);
    assign out_data.status    = status_reg;
    assign out_data.items_added = count_reg;

    // Sequencer: next state, memory port and working registers
    always_comb
    begin
        logic [NW+HW-1:0] s;
        state_next  = state_reg;
        act_next    = act_reg;
        n_next      = n_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        active_next = active_reg;
        count_next  = count_reg;
        status_next = status_reg;
        row_next    = row_reg;
        for (int i = 0; i < 3; i++)
        begin
            div_next[i] = div_reg[i];
            rem_next[i] = rem_reg[i];
        end
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = '0;
        s         = '0;

        unique case (state_reg)
            thbf_pkg::BK_INIT, thbf_pkg::BK_CLEAR:
            begin
                // sweep the store to zero, one row a cycle
                ram_we    = 1'b1;
                ram_waddr = row_reg;
                row_next  = row_reg + 1'b1;
                if (row_reg == ROW_AW'(thbf_pkg::ROWS - 1))
                begin
                    row_next   = '0;
                    state_next = (state_reg == thbf_pkg::BK_INIT) ?
                                 thbf_pkg::BK_IDLE : thbf_pkg::BK_OUT;
                end
            end
            thbf_pkg::BK_IDLE:
            begin
                // take the next request
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    act_next    = thbf_pkg::act_t'(q_data.action);
                    div_next[0] = q_data.elf;
                    div_next[1] = q_data.djb;
                    div_next[2] = q_data.bkdr;
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_next[i] = '0;
                    end
                    n_next     = n_used;
                    step_next  = '0;
                    state_next = thbf_pkg::BK_DIV;
                end
            end
            thbf_pkg::BK_DIV:
            begin
                // reduce all three hashes modulo the bit count
                for (int i = 0; i < 3; i++)
                begin
                    s           = div_step(rem_reg[i], div_reg[i], n_reg);
                    rem_next[i] = s[NW+HW-1:HW];
                    div_next[i] = s[HW-1:0];
                end
                step_next = step_reg + 1'b1;
                idx_next  = '0;
                hit_next  = 1'b1;
                if (step_reg == thbf_pkg::DIV_CW'(thbf_pkg::DIV_CYC - 1))
                begin
                    unique case (act_reg)
                        thbf_pkg::ACT_ADD:
                        begin
                            state_next = thbf_pkg::BK_READ;
                        end
                        thbf_pkg::ACT_CHECK:
                        begin
                            if (active_reg)
                            begin
                                state_next = thbf_pkg::BK_READ;
                            end
                            else
                            begin
                                status_next = thbf_pkg::ST_INACTIVE;
                                state_next  = thbf_pkg::BK_OUT;
                            end
                        end
                        thbf_pkg::ACT_CLEAR:
                        begin
                            active_next = 1'b0;
                            count_next  = '0;
                            status_next = thbf_pkg::ST_DONE;
                            row_next    = '0;
                            state_next  = thbf_pkg::BK_CLEAR;
                        end
                        thbf_pkg::ACT_NOP:
                        begin
                            status_next = thbf_pkg::ST_DONE;
                            state_next  = thbf_pkg::BK_OUT;
                        end
                        default:
                        begin
                            state_next = thbf_pkg::BK_OUT;
                        end
                    endcase
                end
            end
            thbf_pkg::BK_READ:
            begin
                // row address is out, data lands next cycle
                state_next = thbf_pkg::BK_USE;
            end
            thbf_pkg::BK_USE:
            begin
                // set or test one bit of the row
                if (act_reg == thbf_pkg::ACT_ADD)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_row;
                    ram_wdata = ram_rdata | (ROW_W'(1) << pos_bit);
                end
                hit_next = hit_reg & ram_rdata[pos_bit];
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 2'd2)
                begin
                    if (act_reg == thbf_pkg::ACT_ADD)
                    begin
                        active_next = 1'b1;
                        count_next  = count_reg + 32'd1;
                        status_next = thbf_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = (hit_reg & ram_rdata[pos_bit]) ?
                                      thbf_pkg::ST_PRESENT : thbf_pkg::ST_ABSENT;
                    end
                    state_next = thbf_pkg::BK_OUT;
                end
                else
                begin
                    state_next = thbf_pkg::BK_READ;
                end
            end
            thbf_pkg::BK_OUT:
            begin
                // hold the result until taken
                if (!out_stall)
                begin
                    state_next = thbf_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = thbf_pkg::BK_IDLE;
            end
        endcase
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        n_reg    <= n_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        for (int i = 0; i < 3; i++)
        begin
            div_reg[i] <= div_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    // Control and filter status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= thbf_pkg::BK_INIT;
            active_reg <= 1'b0;
            count_reg  <= '0;
            status_reg <= thbf_pkg::ST_DONE;
            row_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCH_LIMIT = 60000;
    localparam int SETTLE = 60;
    localparam int N_ROWS = 16;

    typedef struct {
        thbf_pkg::in_item_t req;
        bit                 typed;
        thbf_pkg::status_t  st;
        logic [31:0]        cnt;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    thbf_pkg::in_item_t            in_data;
    logic                          out_valid;
    logic                          out_stall;
    thbf_pkg::out_item_t           out_data;
    logic                          cfg_wr_en;
    logic [thbf_pkg::CFG_W-1:0]    cfg_wr_data;

    // Filter mirror
    logic [63:0] elf_h, djb_h, bkdr_h;
    bit          bloom_bits [thbf_pkg::MAX_BITS];
    bit          bloom_active;
    logic [31:0] added_cnt;
    logic [thbf_pkg::CFG_W-1:0] bits_in_use;

    thbf_pkg::out_item_t expected_q [$];
    row_t                table_rows [N_ROWS];
    logic [31:0]         key_bank [$];
    int                  key_len_bank [$];
    bit                  failed;
    bit                  quiet;
    int                  stall_left;
    int                  idle_cycles;

    three_hash_bloom_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Fold one request into the mirror; return the result it causes, if any
    task automatic fold_request(input thbf_pkg::in_item_t r, output bit has,
                                output thbf_pkg::out_item_t res);
        logic [63:0] c;
        logic [63:0] top;
        logic [63:0] n, p1, p2, p3;
        thbf_pkg::status_t st;
        c = {{56{r.key_byte[7]}}, r.key_byte};
        elf_h = (elf_h << 4) + c;
        top = elf_h & thbf_pkg::ELF_TOP;
        if (top != 0)
            elf_h = elf_h ^ (top >> 24);
        elf_h = elf_h & ~top;
        djb_h = (djb_h << 5) + djb_h + c;
        bkdr_h = bkdr_h * 64'd131 + c;
        has = r.last_byte;
        res = '0;
        if (!has)
            return;
        if (bits_in_use == 0)
            n = 1;
        else if (bits_in_use > thbf_pkg::MAX_BITS)
            n = thbf_pkg::MAX_BITS;
        else
            n = bits_in_use;
        p1 = elf_h % n;
        p2 = djb_h % n;
        p3 = bkdr_h % n;
        elf_h = 0;
        djb_h = thbf_pkg::DJB_SEED;
        bkdr_h = 0;
        st = thbf_pkg::ST_DONE;
        case (thbf_pkg::act_t'(r.action))
            thbf_pkg::ACT_ADD:
            begin
                bloom_bits[p1] = 1;
                bloom_bits[p2] = 1;
                bloom_bits[p3] = 1;
                bloom_active = 1;
                added_cnt = added_cnt + 1;
            end
            thbf_pkg::ACT_CHECK:
            begin
                if (!bloom_active)
                    st = thbf_pkg::ST_INACTIVE;
                else if (bloom_bits[p1] && bloom_bits[p2] && bloom_bits[p3])
                    st = thbf_pkg::ST_PRESENT;
                else
                    st = thbf_pkg::ST_ABSENT;
            end
            thbf_pkg::ACT_CLEAR:
            begin
                foreach (bloom_bits[i])
                    bloom_bits[i] = 0;
                bloom_active = 0;
                added_cnt = 0;
            end
            default: ;
        endcase
        res.status = st;
        res.items_added = added_cnt;
    endtask

    // Present one request and hold it until taken; returns at the accepting edge
    task automatic send_request(input thbf_pkg::in_item_t r, input bit typed,
                                input thbf_pkg::status_t st, input logic [31:0] cnt);
        bit                  has;
        thbf_pkg::out_item_t res;
        int                  gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        fold_request(r, has, res);
        if (has)
        begin
            if (typed)
            begin
                res.status = st;
                res.items_added = cnt;
            end
            expected_q = {expected_q, res};
        end
    endtask

    task automatic send_key(input thbf_pkg::act_t act, input logic [31:0] key, input int len);
        thbf_pkg::in_item_t r;
        for (int i = 0; i < len; i++)
        begin
            r.action = (i == len - 1) ? act : 2'($urandom);
            r.key_byte = key[8*i +: 8];
            r.last_byte = (i == len - 1);
            send_request(r, 1'b0, thbf_pkg::ST_DONE, '0);
        end
    endtask

    // Drain, let the back end settle, then write the bit count
    task automatic set_bit_count(input logic [thbf_pkg::CFG_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        bits_in_use = v;
    endtask

    // Receiver stall bursts
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each result with the oldest expectation; watch for a hang
    always @(negedge clk)
    begin
        thbf_pkg::out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status %0d items_added %0d",
                       out_data.status, out_data.items_added);
                failed = 1;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_data.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, out_data.status);
                    failed = 1;
                end
                if (out_data.items_added !== e.items_added)
                begin
                    $error("items_added: expected %0d, got %0d",
                           e.items_added, out_data.items_added);
                    failed = 1;
                end
            end
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("three_hash_bloom_filter: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [thbf_pkg::CFG_W-1:0] settings [8];
        logic [31:0]       key;
        int                len, pick, total;
        thbf_pkg::act_t    act;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        out_stall = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        failed = 0;
        quiet = 0;
        rst_n = 1'b0;
        elf_h = 0;
        djb_h = thbf_pkg::DJB_SEED;
        bkdr_h = 0;
        bloom_active = 0;
        added_cnt = 0;
        bits_in_use = thbf_pkg::BIT_COUNT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: inactive check, extremes of the byte, multi-byte key, no-op, clear
        table_rows[0]  = '{'{thbf_pkg::ACT_CHECK, 8'h00, 1'b1}, 1'b1, thbf_pkg::ST_INACTIVE, 32'd0};
        table_rows[1]  = '{'{thbf_pkg::ACT_ADD, 8'hFF, 1'b1}, 1'b1, thbf_pkg::ST_DONE, 32'd1};
        table_rows[2]  = '{'{thbf_pkg::ACT_CHECK, 8'hFF, 1'b1}, 1'b1, thbf_pkg::ST_PRESENT, 32'd1};
        table_rows[3]  = '{'{thbf_pkg::ACT_CHECK, 8'h80, 1'b0}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[4]  = '{'{thbf_pkg::ACT_NOP, 8'h7F, 1'b0}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[5]  = '{'{thbf_pkg::ACT_ADD, 8'h01, 1'b1}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[6]  = '{'{thbf_pkg::ACT_ADD, 8'h80, 1'b0}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[7]  = '{'{thbf_pkg::ACT_CLEAR, 8'h7F, 1'b0}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[8]  = '{'{thbf_pkg::ACT_CHECK, 8'h01, 1'b1}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[9]  = '{'{thbf_pkg::ACT_CHECK, 8'h55, 1'b1}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[10] = '{'{thbf_pkg::ACT_CHECK, 8'hAA, 1'b1}, 1'b0, thbf_pkg::ST_DONE, 32'd0};
        table_rows[11] = '{'{thbf_pkg::ACT_NOP, 8'hAA, 1'b1}, 1'b1, thbf_pkg::ST_DONE, 32'd2};
        table_rows[12] = '{'{thbf_pkg::ACT_CLEAR, 8'h12, 1'b1}, 1'b1, thbf_pkg::ST_DONE, 32'd0};
        table_rows[13] = '{'{thbf_pkg::ACT_CHECK, 8'hFF, 1'b1}, 1'b1, thbf_pkg::ST_INACTIVE, 32'd0};
        table_rows[14] = '{'{thbf_pkg::ACT_ADD, 8'h00, 1'b1}, 1'b1, thbf_pkg::ST_DONE, 32'd1};
        table_rows[15] = '{'{thbf_pkg::ACT_CHECK, 8'h00, 1'b1}, 1'b1, thbf_pkg::ST_PRESENT, 32'd1};
        foreach (table_rows[i])
            send_request(table_rows[i].req, table_rows[i].typed, table_rows[i].st,
                         table_rows[i].cnt);

        // Random keys across bit count settings, extremes included
        settings = '{thbf_pkg::CFG_W'(0), thbf_pkg::CFG_W'(1), thbf_pkg::CFG_W'(37),
                     thbf_pkg::CFG_W'(thbf_pkg::MAX_BITS), {thbf_pkg::CFG_W{1'b1}},
                     thbf_pkg::CFG_W'($urandom_range(2, 4000)), thbf_pkg::CFG_W'(1000),
                     thbf_pkg::BIT_COUNT_RESET};
        total = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_bit_count(settings[ph]);
            if (ph == 7)
                quiet = 1;
            while (total < (ph + 1) * 245)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    act = thbf_pkg::ACT_ADD;
                else if (pick < 92)
                    act = thbf_pkg::ACT_CHECK;
                else if (pick < 98)
                    act = thbf_pkg::ACT_NOP;
                else
                    act = thbf_pkg::ACT_CLEAR;
                if (act != thbf_pkg::ACT_ADD && key_bank.size() != 0 &&
                    $urandom_range(0, 1) == 1)
                begin
                    pick = $urandom_range(0, key_bank.size() - 1);
                    key = key_bank[pick];
                    len = key_len_bank[pick];
                end
                else
                begin
                    key = $urandom;
                    len = $urandom_range(1, 4);
                end
                if (act == thbf_pkg::ACT_ADD && key_bank.size() < 64)
                begin
                    key_bank = {key_bank, key};
                    key_len_bank = {key_len_bank, len};
                end
                send_key(act, key, len);
                total = total + len;
            end
        end

        // Drain and finish
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (!failed && expected_q.size() == 0)
            $display("three_hash_bloom_filter: match");
        else
            $display("three_hash_bloom_filter: mismatch");
        $finish;
    end

endmodule

// File: sim.f
sv/thbf_pkg.sv
sv/thbf_ram.sv
sv/thbf_front.sv
sv/thbf_queue.sv
sv/thbf_back.sv
sv/three_hash_bloom_filter.sv
dv/tb_top.sv
